FILE: rtl/core/sprite_motion_and_frame_animator_unit_assert.svh
// assertion macros shared by the sprite animator rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef SPRITE_MOTION_AND_FRAME_ANIMATOR_UNIT_ASSERT_SVH
`define SPRITE_MOTION_AND_FRAME_ANIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SMFA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smfa assertion failed");

// next-cycle implication
`define SMFA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smfa assertion failed");

`endif

FILE: rtl/core/smfa_pkg.sv
// shared types and constants for the sprite motion and frame animator
// no dependencies
`timescale 1ns / 1ps

package smfa_pkg;

    localparam int SLOTS_DEFAULT      = 4;
    localparam int COORD_W            = 16;
    localparam int CNT_W              = 16;
    localparam int FRAME_W            = 2;
    localparam int COUNT_SHIFT        = 8;
    localparam int MAX_FRAMES         = 2;
    localparam int DIV_BITS_PER_CYCLE = 2;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_PLACE  = 2'd1,
        KIND_MOVE   = 2'd2,
        KIND_TIMING = 2'd3
    } kind_t;

    // one slot record as held in the slot memory
    typedef struct packed {
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_y;
        logic [CNT_W-1:0]   elapsed;
        logic [CNT_W-1:0]   move_len;
        logic [CNT_W-1:0]   frame_timer;
        logic [CNT_W-1:0]   row_counts;
        logic               in_motion;
        logic               active;
        logic               base_row;
        logic [FRAME_W-1:0] shown_frame;
    } slot_rec_t;

    localparam slot_rec_t REC_RESET = '{move_len: CNT_W'(1), default: '0};

    typedef struct packed {
        logic               go;
        logic [COORD_W-1:0] start_val;
        logic [COORD_W-1:0] goal_val;
        logic [CNT_W-1:0]   elapsed;
        logic [CNT_W-1:0]   length;
    } lerp_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COORD_W-1:0] value;
    } lerp_rsp_t;

endpackage

FILE: rtl/core/smfa_lerp.sv
// one-axis interpolator: start + (goal - start) * elapsed / length, truncated
// uses smfa_pkg; multiply, then radix-2 restoring divide, DIV_BITS_PER_CYCLE bits per cycle
`timescale 1ns / 1ps

module smfa_lerp (
    input  logic                clk,
    input  logic                rst_n,
    input  smfa_pkg::lerp_req_t req,
    output smfa_pkg::lerp_rsp_t rsp
);

    localparam int CW     = smfa_pkg::COORD_W;
    localparam int BPC    = smfa_pkg::DIV_BITS_PER_CYCLE;
    localparam int STEPS  = CW / BPC;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIN
    } lerp_state_t;

    lerp_state_t       state_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [CW-1:0]     mag_reg;
    logic [CW-1:0]     el_reg;
    logic [CW-1:0]     len_reg;
    logic [CW-1:0]     base_reg;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     quo_reg;
    logic [CW-1:0]     value_reg;
    logic [STEP_W-1:0] step_reg;

    logic [CW:0]       diff;
    logic [CW:0]       diff_mag;
    logic [2*CW-1:0]   product;
    logic [CW:0]       trial;
    logic [CW-1:0]     rem_step;
    logic [CW-1:0]     quo_step;
    logic [CW-1:0]     q_signed;

    always_comb
    begin
        diff     = {req.goal_val[CW-1], req.goal_val} - {req.start_val[CW-1], req.start_val};
        diff_mag = diff[CW] ? -diff : diff;
        product  = mag_reg * el_reg;
        rem_step = rem_reg;
        quo_step = quo_reg;
        trial    = '0;
        // remainder stays below length, so the shifted trial fits cw+1 bits
        for (int k = 0; k < BPC; k++)
        begin
            trial = {rem_step, quo_step[CW-1]};
            if (trial >= {1'b0, len_reg})
            begin
                trial    = trial - {1'b0, len_reg};
                quo_step = {quo_step[CW-2:0], 1'b1};
            end
            else
            begin
                quo_step = {quo_step[CW-2:0], 1'b0};
            end
            rem_step = trial[CW-1:0];
        end
        q_signed = neg_reg ? -quo_reg : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (req.go)
                    begin
                        neg_reg   <= diff[CW];
                        mag_reg   <= diff_mag[CW-1:0];
                        el_reg    <= req.elapsed;
                        len_reg   <= req.length;
                        base_reg  <= req.start_val;
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    // elapsed < length keeps the high half below the divisor
                    rem_reg   <= product[2*CW-1:CW];
                    quo_reg   <= product[CW-1:0];
                    step_reg  <= '0;
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    rem_reg  <= rem_step;
                    quo_reg  <= quo_step;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(STEPS - 1))
                    begin
                        state_reg <= L_FIN;
                    end
                end
                L_FIN:
                begin
                    value_reg <= base_reg + q_signed;
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy  = (state_reg != L_IDLE);
    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

FILE: rtl/core/sprite_motion_and_frame_animator_unit.sv
// place, move and timing transactions give one result, after the read, evaluate and write-back states
// tick: one result per slot; an idle slot passes through read, evaluate and write-back, an active
// one adds the frame state, and a moving one also waits on the multiply and divide in the interpolators
// one transaction at a time: start is taken only while busy is low; results cannot be stalled
// reset: asynchronous, active low; slot records and delays read as their reset values until
// written (valid bits per entry), so no clearing pass is needed
`timescale 1ns / 1ps
`include "sprite_motion_and_frame_animator_unit_assert.svh"

module sprite_motion_and_frame_animator_unit #(
    parameter int SLOTS = smfa_pkg::SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    // command side
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [1:0]         slot,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [15:0]        amount,
    input  logic [15:0]        frame_counts,
    input  logic [1:0]         delay_index,
    input  logic               visible,
    input  logic               start_row,
    input  logic [2:0]         talker_slot,
    input  logic               talker_active,
    input  logic               cache_writable,
    // result side
    output logic               result_strobe,
    output logic [1:0]         out_slot,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic [1:0]         out_frame,
    output logic               reload_frame,
    output logic               slot_active,
    output logic               any_moving,
    output logic               last
);

    localparam int CW        = smfa_pkg::COORD_W;
    localparam int NW        = smfa_pkg::CNT_W;
    localparam int FW        = smfa_pkg::FRAME_W;
    localparam int SH        = smfa_pkg::COUNT_SHIFT;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DLY_AW    = SLOT_W + FW;
    localparam int DLY_DEPTH = SLOTS * (2 ** FW);
    // wide enough to compare any slot number against SLOTS
    localparam int CMP_W     = 5;

    // sequencer: read slot record, evaluate, read frame delay, wait on divide, write back
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FRAME,
        S_WAIT,
        S_WRITE
    } seq_state_t;

    seq_state_t             state_reg;
    logic [SLOT_W-1:0]      slot_idx_reg;
    logic [SLOTS-1:0]       moving_vec_reg;
    logic [SLOTS-1:0]       moving_next;
    logic                   need_lerp_reg;
    logic                   strobe_reg;

    // slot record memory and frame delay memory, registered reads
    smfa_pkg::slot_rec_t    rec_mem [SLOTS];
    smfa_pkg::slot_rec_t    rec_rd_reg;
    logic [SLOTS-1:0]       rec_valid_reg;
    logic                   rec_rd_valid_reg;
    logic [NW-1:0]          dly_mem [DLY_DEPTH];
    logic [NW-1:0]          dly_rd_reg;
    logic [DLY_DEPTH-1:0]   dly_valid_reg;
    logic                   dly_rd_valid_reg;
    logic [DLY_AW-1:0]      dly_raddr;
    logic [DLY_AW-1:0]      dly_waddr;
    logic                   rec_we;
    logic                   dly_we;

    // captured transaction
    smfa_pkg::kind_t        kind_reg;
    logic [CW-1:0]          pos_x_reg;
    logic [CW-1:0]          pos_y_reg;
    logic [NW-1:0]          amount_reg;
    logic [NW-1:0]          counts_reg;
    logic [FW-1:0]          dly_idx_reg;
    logic                   visible_reg;
    logic                   start_row_reg;
    logic [2:0]             talker_slot_reg;
    logic                   talker_active_reg;
    logic                   writable_reg;

    // working copy of the record being updated
    smfa_pkg::slot_rec_t    work_reg;
    logic [FW-1:0]          frame_reg;
    logic                   cnt_two_reg;
    logic                   reload_reg;

    // result registers
    logic [1:0]             out_slot_reg;
    logic signed [CW-1:0]   out_x_reg;
    logic signed [CW-1:0]   out_y_reg;
    logic [FW-1:0]          out_frame_reg;
    logic                   out_reload_reg;
    logic                   out_active_reg;
    logic                   any_moving_reg;
    logic                   last_reg;

    // combinational helpers
    smfa_pkg::slot_rec_t    rec_eff;
    smfa_pkg::slot_rec_t    eval_rec;
    smfa_pkg::slot_rec_t    frame_rec;
    logic [NW-1:0]          elapsed_inc;
    logic [NW-1:0]          timer_inc;
    logic [NW-1:0]          dly_eff;
    logic [SH-1:0]          row_cnt;
    logic                   eval_row;
    logic [FW-1:0]          eval_frame;
    logic [FW-1:0]          frame_new;
    logic                   eval_cnt_two;
    logic                   eval_reload;
    logic                   frame_reload;
    logic                   talker_hit;
    logic                   lerp_go;
    logic                   is_last;
    logic                   slot_ok;
    logic [SLOT_W+1:0]      slot_wide;
    logic [SLOT_W+1:0]      idx_wide;

    smfa_pkg::lerp_req_t    lx_req;
    smfa_pkg::lerp_req_t    ly_req;
    smfa_pkg::lerp_rsp_t    lx_rsp;
    smfa_pkg::lerp_rsp_t    ly_rsp;

    // addressing
    assign slot_wide = {{SLOT_W{1'b0}}, slot};
    assign idx_wide  = {2'b00, slot_idx_reg};
    assign slot_ok   = ({{(CMP_W-2){1'b0}}, slot} < CMP_W'(SLOTS));
    assign is_last   = (kind_reg != smfa_pkg::KIND_TICK) ||
                       (slot_idx_reg == SLOT_W'(SLOTS - 1));
    assign talker_hit = talker_active_reg &&
                        ({{(CMP_W-3){1'b0}}, talker_slot_reg} == CMP_W'(slot_idx_reg));
    assign dly_raddr = {slot_idx_reg, eval_frame};
    assign dly_waddr = {slot_idx_reg, dly_idx_reg};
    assign rec_we    = (state_reg == S_WRITE);
    assign dly_we    = (state_reg == S_WRITE) && (kind_reg == smfa_pkg::KIND_TIMING);

    // evaluate the record read for this slot
    always_comb
    begin
        rec_eff      = rec_rd_valid_reg ? rec_rd_reg : smfa_pkg::REC_RESET;
        eval_rec     = rec_eff;
        eval_reload  = 1'b0;
        eval_row     = rec_eff.base_row;
        eval_frame   = rec_eff.shown_frame;
        eval_cnt_two = 1'b0;
        elapsed_inc  = rec_eff.elapsed + 1'b1;
        lerp_go      = 1'b0;
        row_cnt      = '0;
        unique case (kind_reg)
            smfa_pkg::KIND_TICK:
            begin
                if (rec_eff.active)
                begin
                    if (rec_eff.in_motion)
                    begin
                        eval_rec.elapsed = elapsed_inc;
                        if (elapsed_inc >= rec_eff.move_len)
                        begin
                            // move done: snap to the goal
                            eval_rec.cur_x     = rec_eff.goal_x;
                            eval_rec.cur_y     = rec_eff.goal_y;
                            eval_rec.in_motion = 1'b0;
                        end
                        else
                        begin
                            lerp_go = (state_reg == S_EVAL);
                        end
                    end
                    // talking row overrides the base row for the speaking slot
                    eval_row = talker_hit | rec_eff.base_row;
                    row_cnt  = eval_row ? rec_eff.row_counts[SH-1:0]
                                        : rec_eff.row_counts[NW-1:SH];
                    // counts clamp to 1..2, so only "two frames" matters
                    eval_cnt_two = (row_cnt >= SH'(smfa_pkg::MAX_FRAMES));
                    if (rec_eff.shown_frame[FW-1] != eval_row)
                    begin
                        eval_frame           = {eval_row, 1'b0};
                        eval_rec.frame_timer = '0;
                    end
                end
            end
            smfa_pkg::KIND_PLACE:
            begin
                eval_rec.cur_x     = pos_x_reg;
                eval_rec.cur_y     = pos_y_reg;
                eval_rec.base_row  = start_row_reg;
                eval_rec.in_motion = 1'b0;
                eval_rec.active    = visible_reg;
                if (visible_reg)
                begin
                    // frame is loaded at once on a visible place
                    eval_rec.shown_frame = {start_row_reg, 1'b0};
                    eval_rec.frame_timer = '0;
                    eval_reload          = 1'b1;
                end
            end
            smfa_pkg::KIND_MOVE:
            begin
                eval_rec.start_x   = rec_eff.cur_x;
                eval_rec.start_y   = rec_eff.cur_y;
                eval_rec.goal_x    = pos_x_reg;
                eval_rec.goal_y    = pos_y_reg;
                eval_rec.move_len  = (amount_reg == '0) ? NW'(1) : amount_reg;
                eval_rec.elapsed   = '0;
                eval_rec.in_motion = 1'b1;
            end
            smfa_pkg::KIND_TIMING:
            begin
                eval_rec.row_counts = counts_reg;
            end
        endcase
    end

    // frame timer against the delay of the current frame
    always_comb
    begin
        dly_eff      = dly_rd_valid_reg ? dly_rd_reg : '0;
        timer_inc    = work_reg.frame_timer + 1'b1;
        frame_rec    = work_reg;
        frame_new    = frame_reg;
        frame_reload = 1'b0;
        if (timer_inc >= dly_eff)
        begin
            frame_rec.frame_timer = '0;
            // phase toggles for a two-frame row, stays at zero for one frame
            frame_new = {frame_reg[FW-1], cnt_two_reg & ~frame_reg[0]};
        end
        else
        begin
            frame_rec.frame_timer = timer_inc;
        end
        if ((frame_new != work_reg.shown_frame) && writable_reg)
        begin
            frame_rec.shown_frame = frame_new;
            frame_reload          = 1'b1;
        end
    end

    always_comb
    begin
        moving_next               = moving_vec_reg;
        moving_next[slot_idx_reg] = work_reg.active & work_reg.in_motion;
    end

    // interpolators for x and y run in lockstep
    assign lx_req.go        = lerp_go;
    assign lx_req.start_val = rec_eff.start_x;
    assign lx_req.goal_val  = rec_eff.goal_x;
    assign lx_req.elapsed   = elapsed_inc;
    assign lx_req.length    = rec_eff.move_len;
    assign ly_req.go        = lerp_go;
    assign ly_req.start_val = rec_eff.start_y;
    assign ly_req.goal_val  = rec_eff.goal_y;
    assign ly_req.elapsed   = elapsed_inc;
    assign ly_req.length    = rec_eff.move_len;

    smfa_lerp u_lerp_x (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lx_req),
        .rsp   (lx_rsp)
    );

    smfa_lerp u_lerp_y (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ly_req),
        .rsp   (ly_rsp)
    );

    // memories: the sequencer never reads a slot in the cycle it is written
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[slot_idx_reg] <= work_reg;
        end
        rec_rd_reg <= rec_mem[slot_idx_reg];
        if (dly_we)
        begin
            dly_mem[dly_waddr] <= amount_reg;
        end
        dly_rd_reg <= dly_mem[dly_raddr];
    end

    // sequencer, valid bits and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slot_idx_reg     <= '0;
            moving_vec_reg   <= '0;
            need_lerp_reg    <= 1'b0;
            strobe_reg       <= 1'b0;
            rec_valid_reg    <= '0;
            dly_valid_reg    <= '0;
            rec_rd_valid_reg <= 1'b0;
            dly_rd_valid_reg <= 1'b0;
        end
        else
        begin
            strobe_reg       <= 1'b0;
            rec_rd_valid_reg <= rec_valid_reg[slot_idx_reg];
            dly_rd_valid_reg <= dly_valid_reg[dly_raddr];
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (kind == smfa_pkg::KIND_TICK)
                        begin
                            slot_idx_reg <= '0;
                            state_reg    <= S_READ;
                        end
                        else if (slot_ok)
                        begin
                            slot_idx_reg <= slot_wide[SLOT_W-1:0];
                            state_reg    <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    need_lerp_reg <= lerp_go;
                    if ((kind_reg == smfa_pkg::KIND_TICK) && rec_eff.active)
                    begin
                        state_reg <= S_FRAME;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_FRAME:
                begin
                    state_reg <= need_lerp_reg ? S_WAIT : S_WRITE;
                end
                S_WAIT:
                begin
                    if (lx_rsp.done)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    strobe_reg                  <= 1'b1;
                    moving_vec_reg              <= moving_next;
                    rec_valid_reg[slot_idx_reg] <= 1'b1;
                    if (dly_we)
                    begin
                        dly_valid_reg[dly_waddr] <= 1'b1;
                    end
                    if (is_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        slot_idx_reg <= slot_idx_reg + 1'b1;
                        state_reg    <= S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_reg          <= smfa_pkg::kind_t'(kind);
                    pos_x_reg         <= pos_x;
                    pos_y_reg         <= pos_y;
                    amount_reg        <= amount;
                    counts_reg        <= frame_counts;
                    dly_idx_reg       <= delay_index;
                    visible_reg       <= visible;
                    start_row_reg     <= start_row;
                    talker_slot_reg   <= talker_slot;
                    talker_active_reg <= talker_active;
                    writable_reg      <= cache_writable;
                end
            end
            S_EVAL:
            begin
                work_reg    <= eval_rec;
                frame_reg   <= eval_frame;
                cnt_two_reg <= eval_cnt_two;
                reload_reg  <= eval_reload;
            end
            S_FRAME:
            begin
                work_reg   <= frame_rec;
                reload_reg <= frame_reload;
            end
            S_WAIT:
            begin
                if (lx_rsp.done)
                begin
                    work_reg.cur_x <= lx_rsp.value;
                    work_reg.cur_y <= ly_rsp.value;
                end
            end
            S_WRITE:
            begin
                out_slot_reg   <= idx_wide[1:0];
                out_x_reg      <= work_reg.cur_x;
                out_y_reg      <= work_reg.cur_y;
                out_frame_reg  <= work_reg.shown_frame;
                out_reload_reg <= reload_reg;
                out_active_reg <= work_reg.active;
                any_moving_reg <= is_last & (|moving_next);
                last_reg       <= is_last;
            end
            default:
            begin
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign out_slot      = out_slot_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_frame     = out_frame_reg;
    assign reload_frame  = out_reload_reg;
    assign slot_active   = out_active_reg;
    assign any_moving    = any_moving_reg;
    assign last          = last_reg;

    // both axes share one schedule
    `SMFA_ASSERT_IMP(a_lerp_lockstep, lx_rsp.done || ly_rsp.done, lx_rsp.done && ly_rsp.done)
    // a divide is only launched into an idle unit
    `SMFA_ASSERT_IMP(a_lerp_free, lerp_go, !lx_rsp.busy && !ly_rsp.busy)
    // every result comes from a write-back
    `SMFA_ASSERT_NXT(a_strobe_follows_write, state_reg == S_WRITE, strobe_reg)
    // motion summary only on the final result of a transaction
    `SMFA_ASSERT_IMP(a_moving_on_last, strobe_reg && !last_reg, !any_moving_reg)

endmodule

FILE: dv/sprite_motion_and_frame_animator_unit_checker.sv
`timescale 1ns / 1ps
// scoreboard for the sprite motion and frame animator: predicts every slot report
// from the accepted command transactions and compares the result stream against it
// depends on smfa_pkg for the command kinds

module sprite_motion_and_frame_animator_unit_checker
    import smfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [1:0]  slot,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] amount,
    input  logic [15:0] frame_counts,
    input  logic [1:0]  delay_index,
    input  logic        visible,
    input  logic        start_row,
    input  logic [2:0]  talker_slot,
    input  logic        talker_active,
    input  logic        cache_writable,
    input  logic        result_strobe,
    input  logic [1:0]  out_slot,
    input  logic [15:0] out_x,
    input  logic [15:0] out_y,
    input  logic [1:0]  out_frame,
    input  logic        reload_frame,
    input  logic        slot_active,
    input  logic        any_moving,
    input  logic        last,
    output int          mismatch_count,
    output int          results_checked,
    output int          expected_pending
);

    localparam int NUM_SLOTS   = 4;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [1:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  frame;
        logic        reload;
        logic        active;
        logic        moving;
        logic        last;
    } slot_report_t;

    // predicted per-slot state
    logic [15:0] cur_x       [NUM_SLOTS];
    logic [15:0] cur_y       [NUM_SLOTS];
    logic [15:0] from_x      [NUM_SLOTS];
    logic [15:0] from_y      [NUM_SLOTS];
    logic [15:0] goal_x      [NUM_SLOTS];
    logic [15:0] goal_y      [NUM_SLOTS];
    logic [15:0] elapsed     [NUM_SLOTS];
    logic [15:0] move_len    [NUM_SLOTS];
    logic [15:0] frame_timer [NUM_SLOTS];
    logic [15:0] row_counts  [NUM_SLOTS];
    logic [15:0] frame_delay [NUM_SLOTS][4];
    logic        in_motion   [NUM_SLOTS];
    logic        active      [NUM_SLOTS];
    logic        base_row    [NUM_SLOTS];
    logic [1:0]  shown_frame [NUM_SLOTS];

    slot_report_t report_q [$];
    slot_report_t observed;
    slot_report_t wanted;
    int           mismatch_n;
    int           checked_n;

    // start + (goal - start) * steps / span, truncated toward zero, kept wide
    function automatic logic [15:0] lerp_axis(input logic [15:0] from_v,
                                              input logic [15:0] to_v,
                                              input logic [15:0] steps,
                                              input logic [15:0] span);
        longint s_v;
        longint d_v;
        longint e_v;
        longint l_v;
        s_v = $signed(from_v);
        d_v = $signed(to_v);
        d_v = d_v - s_v;
        e_v = steps;
        l_v = span;
        return 16'(s_v + (d_v * e_v) / l_v);
    endfunction

    function automatic slot_report_t make_report(input int s, input logic rl,
                                                 input logic mv, input logic lst);
        slot_report_t r;
        r.slot   = 2'(s);
        r.x      = cur_x[s];
        r.y      = cur_y[s];
        r.frame  = shown_frame[s];
        r.reload = rl;
        r.active = active[s];
        r.moving = mv;
        r.last   = lst;
        return r;
    endfunction

    task automatic clear_sprites();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cur_x[i]       = '0;
            cur_y[i]       = '0;
            from_x[i]      = '0;
            from_y[i]      = '0;
            goal_x[i]      = '0;
            goal_y[i]      = '0;
            elapsed[i]     = '0;
            move_len[i]    = 16'd1;
            frame_timer[i] = '0;
            row_counts[i]  = '0;
            in_motion[i]   = 1'b0;
            active[i]      = 1'b0;
            base_row[i]    = 1'b0;
            shown_frame[i] = '0;
            for (int j = 0; j < 4; j++)
                frame_delay[i][j] = '0;
        end
    endtask

    task automatic advance_sprites();
        int          row;
        int          cnt;
        int          f;
        logic [15:0] d;
        logic        rl;
        logic        moving;
        slot_report_t r;
        moving = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            rl = 1'b0;
            if (active[i])
            begin
                if (in_motion[i])
                begin
                    elapsed[i] = elapsed[i] + 16'd1;
                    if (elapsed[i] >= move_len[i])
                    begin
                        cur_x[i]     = goal_x[i];
                        cur_y[i]     = goal_y[i];
                        in_motion[i] = 1'b0;
                    end
                    else
                    begin
                        cur_x[i] = lerp_axis(from_x[i], goal_x[i], elapsed[i], move_len[i]);
                        cur_y[i] = lerp_axis(from_y[i], goal_y[i], elapsed[i], move_len[i]);
                        moving   = 1'b1;
                    end
                end
                row = (talker_active && talker_slot == 3'(i)) ? 1 : int'(base_row[i]);
                cnt = row ? int'(row_counts[i][7:0]) : int'(row_counts[i][15:8]);
                if (cnt < 1)
                    cnt = 1;
                if (cnt > 2)
                    cnt = 2;
                f = shown_frame[i];
                // row change restarts at the first frame of the new row
                if ((f >> 1) != row)
                begin
                    f              = row * 2;
                    frame_timer[i] = '0;
                end
                d = frame_delay[i][f];
                frame_timer[i] = frame_timer[i] + 16'd1;
                if (frame_timer[i] >= d)
                begin
                    frame_timer[i] = '0;
                    f = row * 2 + ((f + 1) % cnt);
                end
                if (2'(f) != shown_frame[i] && cache_writable)
                begin
                    shown_frame[i] = 2'(f);
                    rl = 1'b1;
                end
            end
            r = make_report(i, rl, 1'b0, 1'b0);
            if (i == NUM_SLOTS - 1)
            begin
                r.moving = moving;
                r.last   = 1'b1;
            end
            report_q.push_back(r);
        end
    endtask

    task automatic apply_command();
        logic reload;
        logic moving;
        int   s;
        reload = 1'b0;
        moving = 1'b0;
        s = slot;
        case (kind_t'(kind))
            KIND_PLACE:
            begin
                cur_x[s]     = pos_x;
                cur_y[s]     = pos_y;
                base_row[s]  = start_row;
                in_motion[s] = 1'b0;
                active[s]    = visible;
                if (visible)
                begin
                    shown_frame[s] = {start_row, 1'b0};
                    frame_timer[s] = '0;
                    reload = 1'b1;
                end
            end
            KIND_MOVE:
            begin
                from_x[s]    = cur_x[s];
                from_y[s]    = cur_y[s];
                goal_x[s]    = pos_x;
                goal_y[s]    = pos_y;
                move_len[s]  = (amount == '0) ? 16'd1 : amount;
                elapsed[s]   = '0;
                in_motion[s] = 1'b1;
            end
            default:
            begin
                row_counts[s] = frame_counts;
                frame_delay[s][delay_index] = amount;
            end
        endcase
        for (int i = 0; i < NUM_SLOTS; i++)
            if (active[i] && in_motion[i])
                moving = 1'b1;
        report_q.push_back(make_report(s, reload, moving, 1'b1));
    endtask

    task automatic note_mismatch(input string what, input slot_report_t exp_r,
                                 input slot_report_t act_r);
        mismatch_n++;
        if (mismatch_n <= SHOW_LIMIT)
        begin
            $display("[%0t] %s", $realtime, what);
            $display("  exp slot=%0d x=%0d y=%0d frame=%0d reload=%b act=%b mov=%b last=%b",
                     exp_r.slot, $signed(exp_r.x), $signed(exp_r.y), exp_r.frame,
                     exp_r.reload, exp_r.active, exp_r.moving, exp_r.last);
            $display("  got slot=%0d x=%0d y=%0d frame=%0d reload=%b act=%b mov=%b last=%b",
                     act_r.slot, $signed(act_r.x), $signed(act_r.y), act_r.frame,
                     act_r.reload, act_r.active, act_r.moving, act_r.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sprites();
            report_q.delete();
            mismatch_n       = 0;
            checked_n        = 0;
            mismatch_count   <= 0;
            results_checked  <= 0;
            expected_pending <= 0;
        end
        else
        begin
            if (result_strobe)
            begin
                observed.slot   = out_slot;
                observed.x      = out_x;
                observed.y      = out_y;
                observed.frame  = out_frame;
                observed.reload = reload_frame;
                observed.active = slot_active;
                observed.moving = any_moving;
                observed.last   = last;
                checked_n++;
                if (report_q.size() == 0)
                    note_mismatch("slot report with nothing expected", '0, observed);
                else
                begin
                    wanted = report_q.pop_front();
                    if (observed !== wanted)
                        note_mismatch("slot report differs", wanted, observed);
                end
            end
            if (start && !busy)
            begin
                if (kind_t'(kind) == KIND_TICK)
                    advance_sprites();
                else
                    apply_command();
            end
            mismatch_count   <= mismatch_n;
            results_checked  <= checked_n;
            expected_pending <= report_q.size();
        end
    end

endmodule

FILE: dv/sprite_motion_and_frame_animator_unit_tb.sv
`timescale 1ns / 1ps
// top of the sprite animator testbench: clock, reset, command stimulus and verdict
// depends on smfa_pkg, the rtl top and sprite_motion_and_frame_animator_unit_checker

module sprite_motion_and_frame_animator_unit_tb;

    import smfa_pkg::*;

    localparam int RANDOM_ITEMS   = 410;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 64;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic [1:0]  kind           = '0;
    logic [1:0]  slot           = '0;
    logic [15:0] pos_x          = '0;
    logic [15:0] pos_y          = '0;
    logic [15:0] amount         = '0;
    logic [15:0] frame_counts   = '0;
    logic [1:0]  delay_index    = '0;
    logic        visible        = 1'b0;
    logic        start_row      = 1'b0;
    logic [2:0]  talker_slot    = '0;
    logic        talker_active  = 1'b0;
    logic        cache_writable = 1'b0;

    logic        result_strobe;
    logic [1:0]  out_slot;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [1:0]  out_frame;
    logic        reload_frame;
    logic        slot_active;
    logic        any_moving;
    logic        last;

    int mismatch_count;
    int results_checked;
    int expected_pending;

    // transaction tallies for the closing summary
    int tick_n;
    int place_n;
    int move_n;
    int timing_n;
    // remaining transactions of a back-to-back stretch
    int calm_left;
    int quiet_cycles;

    sprite_motion_and_frame_animator_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .slot           (slot),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .amount         (amount),
        .frame_counts   (frame_counts),
        .delay_index    (delay_index),
        .visible        (visible),
        .start_row      (start_row),
        .talker_slot    (talker_slot),
        .talker_active  (talker_active),
        .cache_writable (cache_writable),
        .result_strobe  (result_strobe),
        .out_slot       (out_slot),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_frame      (out_frame),
        .reload_frame   (reload_frame),
        .slot_active    (slot_active),
        .any_moving     (any_moving),
        .last           (last)
    );

    // the checker sees the same pins and keeps the expected slot reports
    sprite_motion_and_frame_animator_unit_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .slot             (slot),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .amount           (amount),
        .frame_counts     (frame_counts),
        .delay_index      (delay_index),
        .visible          (visible),
        .start_row        (start_row),
        .talker_slot      (talker_slot),
        .talker_active    (talker_active),
        .cache_writable   (cache_writable),
        .result_strobe    (result_strobe),
        .out_slot         (out_slot),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_frame        (out_frame),
        .reload_frame     (reload_frame),
        .slot_active      (slot_active),
        .any_moving       (any_moving),
        .last             (last),
        .mismatch_count   (mismatch_count),
        .results_checked  (results_checked),
        .expected_pending (expected_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle cycles between transactions: mostly none or a few, now and then a long pause,
    // and occasional stretches where commands follow back to back
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = 25;
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // present one command and hold it until the block takes it (start high, busy low)
    task automatic issue_command(input kind_t k, input logic [1:0] s,
                                 input logic [15:0] px, input logic [15:0] py,
                                 input logic [15:0] amt, input logic [15:0] cnts,
                                 input logic [1:0] di, input logic vis, input logic row,
                                 input logic [2:0] tk, input logic talk, input logic wr);
        int gap;
        kind           <= k;
        slot           <= s;
        pos_x          <= px;
        pos_y          <= py;
        amount         <= amt;
        frame_counts   <= cnts;
        delay_index    <= di;
        visible        <= vis;
        start_row      <= row;
        talker_slot    <= tk;
        talker_active  <= talk;
        cache_writable <= wr;
        start          <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (k)
            KIND_TICK:  tick_n++;
            KIND_PLACE: place_n++;
            KIND_MOVE:  move_n++;
            default:    timing_n++;
        endcase
        gap = pick_gap();
        // start only drops when a gap follows, so a back-to-back command keeps it high
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the command side off until every expected slot report has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_pending != 0)
            @(posedge clk);
    endtask

    // ends the run when neither side has moved a transaction for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_strobe)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        kind_t       rk;
        int          r;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] ramt;
        logic [15:0] rcnt;

        tick_n    = 0;
        place_n   = 0;
        move_n    = 0;
        timing_n  = 0;
        calm_left = 0;

        // reset held low from the start, released on a rising edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // tick with every slot still unplaced
        issue_command(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd4, 1'b0, 1'b1);
        // places at the coordinate extremes, both rows, one invisible
        issue_command(KIND_PLACE, 2'd0, 16'h8000, 16'h7fff, 16'h0000, 16'h0000,
                      2'd0, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0);
        issue_command(KIND_PLACE, 2'd1, 16'h7fff, 16'h8000, 16'hffff, 16'hffff,
                      2'd3, 1'b1, 1'b1, 3'd7, 1'b1, 1'b1);
        issue_command(KIND_PLACE, 2'd2, 16'h1234, 16'hedcb, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b1, 3'd0, 1'b0, 1'b0);
        issue_command(KIND_PLACE, 2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0);
        // frame counts of zero and above two are clamped; delays at zero and full scale
        issue_command(KIND_TIMING, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        issue_command(KIND_TIMING, 2'd1, 16'h0000, 16'h0000, 16'h0000, 16'hffff,
                      2'd2, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        issue_command(KIND_TIMING, 2'd1, 16'h0000, 16'h0000, 16'hffff, 16'h0302,
                      2'd3, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        issue_command(KIND_TIMING, 2'd3, 16'h0000, 16'h0000, 16'h0001, 16'h0201,
                      2'd1, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        // duration zero acts as one tick and snaps straight to the target
        issue_command(KIND_MOVE, 2'd0, 16'h7fff, 16'h8000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        // full-scale delta over three ticks exercises signed truncation
        issue_command(KIND_MOVE, 2'd1, 16'h8000, 16'h7fff, 16'h0003, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        // move on a slot that is not visible is kept but does not advance
        issue_command(KIND_MOVE, 2'd2, 16'h0100, 16'hff00, 16'h0002, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        // ticks: cache locked, a talker on a slot, a talker out of range, talking off
        issue_command(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd1, 1'b1, 1'b0);
        issue_command(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd3, 1'b1, 1'b1);
        issue_command(KIND_TICK, 2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      2'd3, 1'b1, 1'b1, 3'd7, 1'b1, 1'b1);
        issue_command(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b1);
        // placing visible drops the pending move
        issue_command(KIND_PLACE, 2'd2, 16'h0010, 16'h0020, 16'h0000, 16'h0000,
                      2'd0, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0);
        // longest possible move, never finishes within the run
        issue_command(KIND_MOVE, 2'd3, 16'h8000, 16'h8000, 16'hffff, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        issue_command(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd2, 1'b1, 1'b1);
        // hide a slot, give it a move, tick, then show it again on the talking row
        issue_command(KIND_PLACE, 2'd0, 16'hfff0, 16'h0008, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        issue_command(KIND_MOVE, 2'd0, 16'h0040, 16'hffc0, 16'h0004, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
        issue_command(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b1, 1'b1);
        issue_command(KIND_PLACE, 2'd0, 16'h0005, 16'h0006, 16'h0000, 16'h0000,
                      2'd0, 1'b1, 1'b1, 3'd0, 1'b0, 1'b0);
        issue_command(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd4, 1'b0, 1'b1);
        issue_command(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      2'd0, 1'b0, 1'b0, 3'd0, 1'b1, 1'b1);

        // ---------------- random part ----------------
        // mostly ticks and moves, places mostly visible, so the animation and motion paths get
        // deep; unused fields carry random noise throughout
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // wait for the result side to empty completely, twice during the run
            if (n == RANDOM_ITEMS / 3 || n == (2 * RANDOM_ITEMS) / 3)
                drain_results();

            r = $urandom_range(0, 99);
            if (r < 50)
                rk = KIND_TICK;
            else if (r < 62)
                rk = KIND_PLACE;
            else if (r < 85)
                rk = KIND_MOVE;
            else
                rk = KIND_TIMING;

            rx   = 16'($urandom);
            ry   = 16'($urandom);
            ramt = 16'($urandom);
            rcnt = 16'($urandom);

            // positions mostly near the origin, sometimes anywhere in range
            if ($urandom_range(0, 99) < 70)
            begin
                rx = 16'($urandom_range(0, 400) - 200);
                ry = 16'($urandom_range(0, 400) - 200);
            end

            if (rk == KIND_MOVE)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    ramt = 16'($urandom_range(1, 12));
                else if (r < 88)
                    ramt = '0;
            end
            else if (rk == KIND_TIMING)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    ramt = 16'($urandom_range(0, 4));
                else if (r < 90)
                    ramt = 16'($urandom_range(5, 30));
                if ($urandom_range(0, 99) < 70)
                    rcnt = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
            end

            issue_command(rk, 2'($urandom), rx, ry, ramt, rcnt, 2'($urandom),
                          ($urandom_range(0, 99) < 80), 1'($urandom), 3'($urandom),
                          1'($urandom), ($urandom_range(0, 99) < 75));
        end

        // let everything come back, then leave room for any stray report
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d ticks, %0d places, %0d moves and %0d timing writes",
                 tick_n, place_n, move_n, timing_n);
        $display("%0d slot reports compared, %0d mismatches", results_checked,
                 mismatch_count);
        if (mismatch_count == 0 && expected_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/smfa_pkg.sv
rtl/core/smfa_lerp.sv
rtl/core/sprite_motion_and_frame_animator_unit.sv
dv/sprite_motion_and_frame_animator_unit_checker.sv
dv/sprite_motion_and_frame_animator_unit_tb.sv
